// File: design/cbl_pkg.sv
// shared types, constants and the character class function of the byte lexer
// no dependencies; imported by every module of the block
`default_nettype none

package cbl_pkg;

   localparam int CHAR_CODES = 256;
   localparam int LINE_BITS  = 24;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int CNT_BITS  = $clog2(RSP_DEPTH + 1);

   // token kinds
   localparam logic [2:0] KIND_WORD = 3'd0;
   localparam logic [2:0] KIND_NUM  = 3'd1;
   localparam logic [2:0] KIND_STR  = 3'd2;
   localparam logic [2:0] KIND_CHAR = 3'd3;
   localparam logic [2:0] KIND_EOL  = 3'd4;
   localparam logic [2:0] KIND_END  = 3'd5;

   // register indexes
   localparam logic [1:0] REG_EOL_TOKENS    = 2'd0;
   localparam logic [1:0] REG_LOWER_CASE    = 2'd1;
   localparam logic [1:0] REG_LINE_COMMENTS = 2'd2;
   localparam logic [1:0] REG_BLOCK_COMMENTS = 2'd3;

   // class bit positions
   localparam int CL_WS    = 0;
   localparam int CL_DIG   = 1;
   localparam int CL_WORD  = 2;
   localparam int CL_QUOTE = 3;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_HIGH   = 8'd128;
   localparam logic [7:0] CHAR_MAX    = 8'd255;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]           token_kind;
      logic [7:0]           token_byte;
      logic                 first_of_token;
      logic                 last_of_token;
      logic                 no_text;
      logic [LINE_BITS-1:0] line_number;
   } rsp_type;

   typedef struct packed {
      logic eol_tokens_on;
      logic lower_case_on;
      logic line_comments_on;
      logic block_comments_on;
   } cfg_type;

   // up to two results per accepted byte
   typedef struct packed {
      logic [1:0]    count;
      rsp_type [1:0] slot;
   } push_type;

   function automatic logic [3:0] cls_of(input logic [7:0] b);
      logic [3:0] c;
      c = 4'b0000;
      if (32'(b) >= CHAR_CODES) begin
         c[CL_WORD] = 1'b1;
      end else begin
         if (b <= CHAR_SPACE) c[CL_WS] = 1'b1;
         if (b inside {[8'h61:8'h7A], [8'h41:8'h5A], CHAR_UNDER, [CHAR_HIGH:CHAR_MAX]})
            c[CL_WORD] = 1'b1;
         if (b inside {[8'h30:8'h39], CHAR_MINUS}) c[CL_DIG] = 1'b1;
         if (b inside {CHAR_DQUOTE, CHAR_SQUOTE}) c[CL_QUOTE] = 1'b1;
      end
      return c;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] kind, input logic [7:0] tb,
                                        input logic first, input logic last,
                                        input logic notext,
                                        input logic [LINE_BITS-1:0] line);
      rsp_type r;
      r.token_kind     = kind;
      r.token_byte     = tb;
      r.first_of_token = first;
      r.last_of_token  = last;
      r.no_text        = notext;
      r.line_number    = line;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/cbl_core.sv
// lexer state and per-byte decisions, one byte a cycle while accept is high
// depends on cbl_pkg; produces up to two results per transfer for the queue
`default_nettype none

module cbl_core
   import cbl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output push_type     push
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_MINUS,
      MODE_STR,
      MODE_SLASH,
      MODE_LCOM,
      MODE_BCOM
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [7:0]           held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   logic [7:0]           quote_ff, quote_in;
   logic [7:0]           prev_ff, prev_in;
   logic                 started_ff, started_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   // held byte as a result, folded to lower case for words when enabled
   function automatic rsp_type held_rsp(input logic [2:0] kind, input logic [7:0] hb,
                                        input logic started, input logic last,
                                        input logic lc,
                                        input logic [LINE_BITS-1:0] line);
      logic [7:0] tb;
      tb = hb;
      if (kind == KIND_WORD && lc && (hb inside {[8'h41:8'h5A]})) tb = hb + CASE_OFFSET;
      return make_rsp(kind, tb, ~started, last, 1'b0, line);
   endfunction

   always_comb begin
      logic [1:0]    n;
      rsp_type [1:0] slot;
      logic          do_idle;
      logic [7:0]    b;
      logic [3:0]    c;

      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      quote_in      = quote_ff;
      prev_in       = prev_ff;
      started_in    = started_ff;
      line_in       = line_ff;
      n             = 2'd0;
      slot          = '0;
      do_idle       = 1'b0;
      b             = req.in_byte;
      c             = cls_of(b);

      if (accept && req.end_of_input) begin
         case (mode_ff)
            MODE_WORD, MODE_NUM: begin
               slot[n[0]] = held_rsp((mode_ff == MODE_WORD) ? KIND_WORD : KIND_NUM,
                                     held_in, started_in, 1'b1, cfg.lower_case_on, line_in);
               n = n + 2'd1;
            end
            MODE_MINUS, MODE_SLASH: begin
               slot[n[0]] = make_rsp(KIND_CHAR, held_in, 1'b1, 1'b1, 1'b0, line_in);
               n = n + 2'd1;
            end
            MODE_STR: begin
               if (held_valid_in) begin
                  slot[n[0]] = held_rsp(KIND_STR, held_in, started_in, 1'b1,
                                        cfg.lower_case_on, line_in);
               end else begin
                  slot[n[0]] = make_rsp(KIND_STR, 8'h00, 1'b1, 1'b1, 1'b1, line_in);
               end
               n = n + 2'd1;
            end
            default: ;
         endcase
         slot[n[0]] = make_rsp(KIND_END, 8'h00, 1'b1, 1'b1, 1'b1, line_in);
         n             = n + 2'd1;
         mode_in       = MODE_IDLE;
         held_in       = 8'h00;
         held_valid_in = 1'b0;
         quote_in      = 8'h00;
         prev_in       = 8'h00;
         started_in    = 1'b0;
      end else if (accept) begin
         case (mode_ff)
            MODE_WORD, MODE_NUM: begin
               if ((mode_ff == MODE_WORD) ? c[CL_WORD] : (c[CL_DIG] || b == CHAR_DOT)) begin
                  slot[n[0]] = held_rsp((mode_ff == MODE_WORD) ? KIND_WORD : KIND_NUM,
                                        held_in, started_in, 1'b0, cfg.lower_case_on,
                                        line_in);
                  n          = n + 2'd1;
                  started_in = 1'b1;
                  held_in    = b;
               end else begin
                  slot[n[0]] = held_rsp((mode_ff == MODE_WORD) ? KIND_WORD : KIND_NUM,
                                        held_in, started_in, 1'b1, cfg.lower_case_on,
                                        line_in);
                  n          = n + 2'd1;
                  started_in = 1'b0;
                  do_idle    = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (c[CL_DIG] && b != CHAR_MINUS) begin
                  slot[n[0]] = held_rsp(KIND_NUM, held_in, 1'b0, 1'b0,
                                        cfg.lower_case_on, line_in);
                  n          = n + 2'd1;
                  started_in = 1'b1;
                  mode_in    = MODE_NUM;
                  held_in    = b;
               end else begin
                  slot[n[0]] = make_rsp(KIND_CHAR, held_in, 1'b1, 1'b1, 1'b0, line_in);
                  n          = n + 2'd1;
                  do_idle    = 1'b1;
               end
            end
            MODE_STR: begin
               if (b == quote_ff || b == CHAR_NL || b == CHAR_CR) begin
                  if (held_valid_in) begin
                     slot[n[0]] = held_rsp(KIND_STR, held_in, started_in, 1'b1,
                                           cfg.lower_case_on, line_in);
                  end else begin
                     slot[n[0]] = make_rsp(KIND_STR, 8'h00, 1'b1, 1'b1, 1'b1, line_in);
                  end
                  n             = n + 2'd1;
                  held_valid_in = 1'b0;
                  started_in    = 1'b0;
                  mode_in       = MODE_IDLE;
                  // a line break ends the string and is then lexed itself
                  do_idle       = (b != quote_ff);
               end else begin
                  if (held_valid_in) begin
                     slot[n[0]] = held_rsp(KIND_STR, held_in, started_in, 1'b0,
                                           cfg.lower_case_on, line_in);
                     n          = n + 2'd1;
                     started_in = 1'b1;
                  end
                  held_in       = b;
                  held_valid_in = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (b == CHAR_SLASH && cfg.line_comments_on) begin
                  mode_in       = MODE_LCOM;
                  held_valid_in = 1'b0;
               end else if (b == CHAR_STAR && cfg.block_comments_on) begin
                  mode_in       = MODE_BCOM;
                  held_valid_in = 1'b0;
                  prev_in       = 8'h00;
               end else begin
                  slot[n[0]] = make_rsp(KIND_CHAR, held_in, 1'b1, 1'b1, 1'b0, line_in);
                  n          = n + 2'd1;
                  do_idle    = 1'b1;
               end
            end
            MODE_LCOM: begin
               if (b == CHAR_NL || b == CHAR_CR) do_idle = 1'b1;
            end
            MODE_BCOM: begin
               if (b == CHAR_NL && line_in != '1) line_in = line_in + LINE_BITS'(1);
               if (b == CHAR_SLASH && prev_ff == CHAR_STAR) begin
                  mode_in = MODE_IDLE;
                  prev_in = 8'h00;
               end else begin
                  prev_in = b;
               end
            end
            default: do_idle = 1'b1;
         endcase

         // byte seen between tokens
         if (do_idle) begin
            mode_in       = MODE_IDLE;
            held_valid_in = 1'b0;
            started_in    = 1'b0;
            if (c[CL_WS]) begin
               if (b == CHAR_NL) begin
                  if (line_in != '1) line_in = line_in + LINE_BITS'(1);
                  if (cfg.eol_tokens_on) begin
                     slot[n[0]] = make_rsp(KIND_EOL, 8'h00, 1'b1, 1'b1, 1'b1, line_in);
                     n          = n + 2'd1;
                  end
               end
            end else if (c[CL_DIG] || c[CL_WORD]) begin
               mode_in       = c[CL_DIG] ? ((b == CHAR_MINUS) ? MODE_MINUS : MODE_NUM)
                                         : MODE_WORD;
               held_in       = b;
               held_valid_in = 1'b1;
            end else if (c[CL_QUOTE]) begin
               mode_in  = MODE_STR;
               quote_in = b;
            end else if (b == CHAR_SLASH && (cfg.line_comments_on || cfg.block_comments_on)) begin
               mode_in       = MODE_SLASH;
               held_in       = b;
               held_valid_in = 1'b1;
            end else begin
               slot[n[0]] = make_rsp(KIND_CHAR, b, 1'b1, 1'b1, 1'b0, line_in);
               n          = n + 2'd1;
            end
         end
      end

      push.count = n;
      push.slot  = slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_ff       <= 8'h00;
         held_valid_ff <= 1'b0;
         quote_ff      <= 8'h00;
         prev_ff       <= 8'h00;
         started_ff    <= 1'b0;
         line_ff       <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         quote_ff      <= quote_in;
         prev_ff       <= prev_in;
         started_ff    <= started_in;
         line_ff       <= line_in;
      end
   end

endmodule

`default_nettype wire

// File: design/cbl_rsp_queue.sv
// small queue: up to two results in a cycle, one out unless rsp_stall
// depends on cbl_pkg; sits between the lexer core and the result port
`default_nettype none

module cbl_rsp_queue
   import cbl_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   rsp_type [RSP_DEPTH-1:0] entry_ff;
   logic [PTR_BITS-1:0]     wr_ff, wr_in;
   logic [PTR_BITS-1:0]     rd_ff, rd_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [PTR_BITS-1:0]     wr_second;
   logic                    pop;

   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ff];
   // room for a worst-case pair of results
   assign room        = (count_ff <= CNT_BITS'(RSP_DEPTH - 2));
   assign wr_second   = wr_ff + PTR_BITS'(1);
   assign wr_in       = wr_ff + PTR_BITS'(push.count);
   assign rd_in       = rd_ff + PTR_BITS'(pop);
   assign count_in    = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.slot[0];
      if (push.count == 2'd2) entry_ff[wr_second] <= push.slot[1];
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CNT_BITS'(RSP_DEPTH - 2))
      else $error("results pushed without room for a pair");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - CNT_BITS'(1))
      else $error("queue fill not reduced by a lone transfer out");

endmodule

`default_nettype wire

// File: design/configurable_byte_lexer.sv
// byte lexer: one byte per transfer in, token results out through a 4-entry queue
// results are written to the queue and offered on rsp from its head in order
// throughput: one byte per cycle; bytes yielding two results drain one per cycle
// when rsp_stall is low; req_stall rises while more than two results are queued
// reset is synchronous: lexer idle, line count zero, queue empty, registers default
`default_nettype none

module configurable_byte_lexer
   import cbl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   logic     room;
   logic     accept;
   logic     csr_write;

   assign pready    = 1'b1;
   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_EOL_TOKENS:     cfg_in.eol_tokens_on     = pwdata[0];
            REG_LOWER_CASE:     cfg_in.lower_case_on     = pwdata[0];
            REG_LINE_COMMENTS:  cfg_in.line_comments_on  = pwdata[0];
            REG_BLOCK_COMMENTS: cfg_in.block_comments_on = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_EOL_TOKENS:     prdata = {31'd0, cfg_ff.eol_tokens_on};
         REG_LOWER_CASE:     prdata = {31'd0, cfg_ff.lower_case_on};
         REG_LINE_COMMENTS:  prdata = {31'd0, cfg_ff.line_comments_on};
         REG_BLOCK_COMMENTS: prdata = {31'd0, cfg_ff.block_comments_on};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eol_tokens_on     <= 1'b0;
         cfg_ff.lower_case_on     <= 1'b0;
         cfg_ff.line_comments_on  <= 1'b1;
         cfg_ff.block_comments_on <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg_ff),
      .push   (push)
   );

   cbl_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
